// ===== design/mscg_pkg.sv =====
// Shared types and constants of the multi-stop color gradient unit.
package mscg_pkg;

   localparam int unsigned POS_W    = 16;
   localparam int unsigned OFF_W    = 16;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned COLOR_W  = 3 * CHAN_W;
   localparam int unsigned STOP_W   = OFF_W + COLOR_W;
   localparam int unsigned COUNT_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned WEIGHT_W = 9;
   localparam int unsigned REM_W    = OFF_W + 1;
   localparam int unsigned DIV_STEPS = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_BASE  = 3'd1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type             color_l;
      rgb_type             color_r;
      logic [REM_W-1:0]    rem;
      logic [OFF_W-1:0]    den;
      logic [WEIGHT_W-1:0] quot;
   } div_type;

endpackage

// ===== design/multi_stop_color_gradient_unit.sv =====
// Top level of the multi-stop color gradient unit.
//
// Each request on the req_ channel carries one 16-bit gradient position; the
// block answers with exactly one 24-bit RGB color on the rsp_ channel, in order.
// The gradient is set through the csr_ write port: index 0 holds the number of
// stops in use, indexes 1 to 6 hold the stops (offset in bits 39..24, then red,
// green, blue). Write the registers only while no request is in flight.
//
// The datapath is a six-stage pipeline: segment search, three division stages
// of three quotient bits each for the 9-bit blend weight, the weight products,
// and the channel sums in the output register. The pipeline takes one request per
// cycle as long as the receiver does not stall it by holding rsp_tready low.
// Every stage carries its own valid bit and advances when it is empty or when
// the stage after it advances, so a stalled receiver lets the pipeline fill up
// its empty slots before req_tready falls; nothing is dropped or repeated.
// Reset clears the stop registers (zero stops, so black) and empties the pipe.
module multi_stop_color_gradient_unit #(
   parameter int unsigned MAX_STOPS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [15:0] position
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic                               csr_wen,
   input  logic [mscg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mscg_pkg::STOP_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [mscg_pkg::COUNT_W-1:0]               count_ff;
   logic [mscg_pkg::COUNT_W-1:0]               count_in;
   logic [MAX_STOPS-1:0][mscg_pkg::STOP_W-1:0] stop_ff;
   logic [MAX_STOPS-1:0][mscg_pkg::STOP_W-1:0] stop_in;

   // Pipeline handshake between stages.
   logic              v_sel, v_div_a, v_div_b, v_div_c, v_mul, v_out;
   logic              adv_sel, adv_div_a, adv_div_b, adv_div_c, adv_mul, adv_out;
   mscg_pkg::div_type d_sel, d_div_a, d_div_b, d_div_c;
   mscg_pkg::rgb_type color;

   always_comb begin
      count_in = count_ff;
      stop_in  = stop_ff;
      if (csr_wen) begin
         if (csr_index == mscg_pkg::CSR_STOP_COUNT) begin
            count_in = csr_wdata[mscg_pkg::COUNT_W-1:0];
         end
         for (int j = 0; j < MAX_STOPS; j++) begin
            if (csr_index == mscg_pkg::CSR_IDX_W'(j) + mscg_pkg::CSR_STOP_BASE) begin
               stop_in[j] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stop_ff  <= '0;
      end else begin
         count_ff <= count_in;
         stop_ff  <= stop_in;
      end
   end

   // A stage moves when it is empty or when the stage after it moves.
   assign adv_out   = !v_out   || rsp_tready;
   assign adv_mul   = !v_mul   || adv_out;
   assign adv_div_c = !v_div_c || adv_mul;
   assign adv_div_b = !v_div_b || adv_div_c;
   assign adv_div_a = !v_div_a || adv_div_b;
   assign adv_sel   = !v_sel   || adv_div_a;
   assign req_tready = adv_sel;

   mscg_select #(
      .MAX_STOPS (MAX_STOPS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv_sel),
      .in_valid   (req_tvalid),
      .position   (req_tdata),
      .stop_count (count_ff),
      .stops      (stop_ff),
      .out_valid  (v_sel),
      .out_data   (d_sel)
   );

   mscg_divide u_divide_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_div_a),
      .in_valid  (v_sel),
      .in_data   (d_sel),
      .out_valid (v_div_a),
      .out_data  (d_div_a)
   );

   mscg_divide u_divide_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_div_b),
      .in_valid  (v_div_a),
      .in_data   (d_div_a),
      .out_valid (v_div_b),
      .out_data  (d_div_b)
   );

   mscg_divide u_divide_c (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_div_c),
      .in_valid  (v_div_b),
      .in_data   (d_div_b),
      .out_valid (v_div_c),
      .out_data  (d_div_c)
   );

   mscg_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .advance_mul (adv_mul),
      .advance_out (adv_out),
      .in_valid    (v_div_c),
      .in_data     (d_div_c),
      .mid_valid   (v_mul),
      .out_valid   (v_out),
      .out_color   (color)
   );

   assign rsp_tvalid = v_out;
   assign rsp_tdata  = {color.blue, color.green, color.red};

`ifndef SYNTHESIS
   // A receiver that is ready lets every stage move, so requests are taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request side stalled while receiver is ready");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With zero stops configured, a full pipe of requests yields black only.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && $past(count_ff == '0, 6) && !$past(reset, 6) &&
       !$past(csr_wen, 6) && rsp_tvalid && $past(v_out) == 1'b0 &&
       $past(count_ff == '0, 1) && $past(count_ff == '0, 2) &&
       $past(count_ff == '0, 3) && $past(count_ff == '0, 4) &&
       $past(count_ff == '0, 5)) |-> (rsp_tdata == '0))
      else $error("nonzero color with no stops");
`endif

endmodule

// ===== design/mscg_select.sv =====
// Segment search stage: picks the gradient segment and sets up the weight division.
module mscg_select #(
   parameter int unsigned MAX_STOPS = 6
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              advance,
   input  logic                                              in_valid,
   input  logic [mscg_pkg::POS_W-1:0]                        position,
   input  logic [mscg_pkg::COUNT_W-1:0]                      stop_count,
   input  logic [MAX_STOPS-1:0][mscg_pkg::STOP_W-1:0]        stops,
   output logic                                              out_valid,
   output mscg_pkg::div_type                                 out_data
);

   localparam int unsigned IDX_W = $clog2(MAX_STOPS);

   logic [mscg_pkg::COUNT_W-1:0] n_used;
   logic                         found;
   logic [IDX_W-1:0]             sel;
   logic [IDX_W-1:0]             sel_r;
   logic [IDX_W-1:0]             last;
   logic [mscg_pkg::OFF_W-1:0]   off_lo;
   logic [mscg_pkg::OFF_W-1:0]   off_hi;
   mscg_pkg::div_type            data_in;
   mscg_pkg::div_type            data_ff;
   logic                         valid_ff;

   always_comb begin
      n_used = (stop_count > mscg_pkg::COUNT_W'(MAX_STOPS)) ?
               mscg_pkg::COUNT_W'(MAX_STOPS) : stop_count;
      found = 1'b0;
      sel   = '0;
      // Walk downward so the lowest matching segment wins.
      for (int i = MAX_STOPS - 2; i >= 0; i--) begin
         if ((mscg_pkg::COUNT_W'(i) + 3'd1) < n_used &&
             position <= stops[i+1][mscg_pkg::STOP_W-1:mscg_pkg::COLOR_W]) begin
            found = 1'b1;
            sel   = IDX_W'(i);
         end
      end
      sel_r  = sel + IDX_W'(1);
      last   = IDX_W'(n_used - 3'd1);
      off_lo = stops[sel][mscg_pkg::STOP_W-1:mscg_pkg::COLOR_W];
      off_hi = stops[sel_r][mscg_pkg::STOP_W-1:mscg_pkg::COLOR_W];

      // A single color is sent through the blend with weight zero.
      data_in.color_l = mscg_pkg::rgb_type'(stops[0][mscg_pkg::COLOR_W-1:0]);
      data_in.rem     = '0;
      data_in.den     = mscg_pkg::OFF_W'(1);
      data_in.quot    = '0;
      if (n_used == 3'd0) begin
         data_in.color_l = '0;
      end else if (n_used == 3'd1 ||
                   position < stops[0][mscg_pkg::STOP_W-1:mscg_pkg::COLOR_W]) begin
         data_in.color_l = mscg_pkg::rgb_type'(stops[0][mscg_pkg::COLOR_W-1:0]);
      end else if (found) begin
         if (off_hi <= off_lo) begin
            data_in.color_l = mscg_pkg::rgb_type'(stops[sel_r][mscg_pkg::COLOR_W-1:0]);
         end else begin
            data_in.color_l = mscg_pkg::rgb_type'(stops[sel][mscg_pkg::COLOR_W-1:0]);
            data_in.rem     = {1'b0, position - off_lo};
            data_in.den     = off_hi - off_lo;
         end
      end else begin
         data_in.color_l = mscg_pkg::rgb_type'(stops[last][mscg_pkg::COLOR_W-1:0]);
      end
      if (found && n_used > 3'd1 && off_hi > off_lo &&
          position >= stops[0][mscg_pkg::STOP_W-1:mscg_pkg::COLOR_W]) begin
         data_in.color_r = mscg_pkg::rgb_type'(stops[sel_r][mscg_pkg::COLOR_W-1:0]);
      end else begin
         data_in.color_r = data_in.color_l;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/mscg_divide.sv =====
// Weight division stage: three restoring quotient steps per register stage.
module mscg_divide (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  mscg_pkg::div_type in_data,
   output logic              out_valid,
   output mscg_pkg::div_type out_data
);

   logic [mscg_pkg::REM_W-1:0]    r;
   logic [mscg_pkg::WEIGHT_W-1:0] q;
   logic                          qbit;
   mscg_pkg::div_type             data_in;
   mscg_pkg::div_type             data_ff;
   logic                          valid_ff;

   // Each step compares the partial remainder with the divisor, subtracts on a
   // hit, and shifts in the next (zero) dividend bit.
   always_comb begin
      r = in_data.rem;
      q = in_data.quot;
      for (int s = 0; s < mscg_pkg::DIV_STEPS; s++) begin
         qbit = (r >= {1'b0, in_data.den});
         if (qbit) begin
            r = r - {1'b0, in_data.den};
         end
         q = {q[mscg_pkg::WEIGHT_W-2:0], qbit};
         r = {r[mscg_pkg::REM_W-2:0], 1'b0};
      end
      data_in      = in_data;
      data_in.rem  = r;
      data_in.quot = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef SYNTHESIS
   // The remainder stays below twice a nonzero divisor between stages.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.den != '0 && data_ff.rem < {data_ff.den, 1'b0}))
      else $error("divide remainder out of range");
`endif

endmodule

// ===== design/mscg_blend.sv =====
// Color blend: weight products in one stage, channel sums in the output stage.
module mscg_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance_mul,
   input  logic                       advance_out,
   input  logic                       in_valid,
   input  mscg_pkg::div_type          in_data,
   output logic                       mid_valid,
   output logic                       out_valid,
   output mscg_pkg::rgb_type          out_color
);

   localparam int unsigned PROD_W = mscg_pkg::CHAN_W + mscg_pkg::WEIGHT_W;

   logic [mscg_pkg::WEIGHT_W-1:0]          w_inv;
   logic [2:0][mscg_pkg::CHAN_W-1:0]       chan_l;
   logic [2:0][mscg_pkg::CHAN_W-1:0]       chan_r;
   logic [2:0][PROD_W-1:0]                 prod_l_in;
   logic [2:0][PROD_W-1:0]                 prod_r_in;
   logic [2:0][PROD_W-1:0]                 prod_l_ff;
   logic [2:0][PROD_W-1:0]                 prod_r_ff;
   logic [2:0][PROD_W-1:0]                 sum;
   mscg_pkg::rgb_type                      color_in;
   mscg_pkg::rgb_type                      color_ff;
   logic                                   mid_ff;
   logic                                   out_ff;

   always_comb begin
      w_inv  = mscg_pkg::WEIGHT_ONE - in_data.quot;
      chan_l = in_data.color_l;
      chan_r = in_data.color_r;
      for (int c = 0; c < 3; c++) begin
         prod_l_in[c] = PROD_W'(chan_l[c]) * PROD_W'(w_inv);
         prod_r_in[c] = PROD_W'(chan_r[c]) * PROD_W'(in_data.quot);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = prod_l_ff[c] + prod_r_ff[c];
      end
      color_in.red   = sum[2][2*mscg_pkg::CHAN_W-1:mscg_pkg::CHAN_W];
      color_in.green = sum[1][2*mscg_pkg::CHAN_W-1:mscg_pkg::CHAN_W];
      color_in.blue  = sum[0][2*mscg_pkg::CHAN_W-1:mscg_pkg::CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         if (advance_mul) begin
            mid_ff <= in_valid;
         end
         if (advance_out) begin
            out_ff <= mid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance_mul) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (advance_out) begin
         color_ff <= color_in;
      end
   end

   assign mid_valid = mid_ff;
   assign out_valid = out_ff;
   assign out_color = color_ff;

`ifndef SYNTHESIS
   // A finished division never yields a weight above one.
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (in_data.quot <= mscg_pkg::WEIGHT_ONE))
      else $error("blend weight above one");
`endif

endmodule
